// File: rtl/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared types and constants for the range set merge core: field widths,
// operation and status codes, the table entry and result records, and the
// controller states.
// ----------------------------------------------------------------------------
package rsm_pkg;

  // default number of table entries
  localparam int unsigned TABLE_DEPTH = 32;

  // field widths
  localparam int unsigned OFF_W  = 48;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned LEN_W  = 49;

  // operation codes of an input beat
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MERGE = 2'd1,
    OP_EMIT  = 2'd2
  } op_e;

  // status codes of a result beat
  typedef enum logic [2:0] {
    STATUS_APPENDED = 3'd0,
    STATUS_EXTENDED = 3'd1,
    STATUS_DROPPED  = 3'd2,
    STATUS_ENTRY    = 3'd3,
    STATUS_EMPTY    = 3'd4
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_EXTEND,
    ST_SORT,
    ST_RESULT
  } state_e;

  // one table entry as held in the memory
  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [LEN_W-1:0] length;
    logic             flag;
  } entry_t;

  // one result beat
  typedef struct packed {
    status_e          status;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] size;
    logic             changed;
    logic             last;
  } result_t;

endpackage

// File: rtl/rsm_mem.sv
// ----------------------------------------------------------------------------
// rsm_mem
// Range table storage: one write port and one read port, read data
// registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module rsm_mem #(
  parameter int unsigned TableDepth = rsm_pkg::TABLE_DEPTH,
  parameter int unsigned IdxW       = $clog2(TableDepth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IdxW-1:0]      waddr_i,
  input  rsm_pkg::entry_t      wdata_i,
  input  logic                 re_i,
  input  logic [IdxW-1:0]      raddr_i,
  output rsm_pkg::entry_t      rdata_o
);

  rsm_pkg::entry_t mem_q [TableDepth];
  rsm_pkg::entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/range_set_merge_core.sv
// ----------------------------------------------------------------------------
// range_set_merge_core
// Table of byte ranges with unchecked load, first-match merge, and a sorted
// emit that clears the table. Entries sit in a single-port-read memory.
// ----------------------------------------------------------------------------
// Load: an accepted beat goes through the append state, then the result state.
// Merge: walks the stored entries in order, one memory read a cycle.
// Emit: one selection pass over the table plus a result beat per entry;
//   an empty table answers with a single empty-status result beat.
// One item is worked on at a time; a new beat is taken while a result waits in the output register.
// Reset clears the entry count and control state; the memory is not cleared.
module range_set_merge_core #(
  parameter int unsigned TableDepth = rsm_pkg::TABLE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                operation_i,
  input  logic [rsm_pkg::OFF_W-1:0] range_offset_i,
  input  logic [rsm_pkg::SIZE_W-1:0] range_size_i,
  input  logic                      range_changed_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                status_o,
  output logic [rsm_pkg::OFF_W-1:0] out_offset_o,
  output logic [rsm_pkg::LEN_W-1:0] out_size_o,
  output logic                      out_changed_o,
  output logic                      last_o
);

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned OffW = rsm_pkg::OFF_W;
  localparam int unsigned SizeW = rsm_pkg::SIZE_W;
  localparam int unsigned LenW = rsm_pkg::LEN_W;

  rsm_pkg::state_e state_q, state_d;

  // captured input beat
  logic [OffW-1:0]  off_q, off_d;
  logic [SizeW-1:0] size_q, size_d;
  logic             chg_q, chg_d;

  // table fill and scan bookkeeping
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  scan_q, scan_d;
  logic             rd_pend_q, rd_pend_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;

  // merge hit
  rsm_pkg::entry_t  hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic [OffW-1:0]  hit_dist_q, hit_dist_d;

  // sort selection
  logic             best_vld_q, best_vld_d;
  rsm_pkg::entry_t  best_q, best_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic             prev_vld_q, prev_vld_d;
  logic [OffW-1:0]  prev_start_q, prev_start_d;
  logic [IdxW-1:0]  prev_idx_q, prev_idx_d;
  logic [CntW-1:0]  emit_cnt_q, emit_cnt_d;

  // pending result and output register
  rsm_pkg::result_t res_q, res_d;
  logic             out_valid_q, out_valid_d;
  rsm_pkg::result_t out_q, out_d;

  // memory ports
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr;
  rsm_pkg::entry_t  mem_wdata, mem_rdata;

  // shared decode
  logic             issue_room, room, hit, pass_end, eligible, better, out_free, emit_last;
  logic [OffW:0]    off_delta;
  logic [LenW-1:0]  ext_sum, ext_len;

  rsm_mem #(
    .TableDepth (TableDepth),
    .IdxW       (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  // entry compare against the captured offset
  assign off_delta  = {1'b0, off_q} - {1'b0, mem_rdata.start};
  assign hit        = rd_pend_q && !off_delta[OffW] &&
                      ({1'b0, off_delta[OffW-1:0]} < mem_rdata.length);
  assign issue_room = (scan_q < cnt_q);
  assign pass_end   = !rd_pend_q && !issue_room;
  assign room       = (cnt_q < CntW'(TableDepth));

  // sort key order: (start, index) strictly after the previous beat, lowest start wins
  assign eligible = !prev_vld_q || (mem_rdata.start > prev_start_q) ||
                    ((mem_rdata.start == prev_start_q) && (rd_idx_q > prev_idx_q));
  assign better   = !best_vld_q || (mem_rdata.start < best_q.start);
  assign emit_last = ((emit_cnt_q + CntW'(1)) == cnt_q);

  // extended length from registered hit values
  assign ext_sum = {1'b0, hit_dist_q} + {{(LenW - SizeW){1'b0}}, size_q};
  assign ext_len = (ext_sum > hit_q.length) ? ext_sum : hit_q.length;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          priority case (operation_i)
            rsm_pkg::OP_LOAD:  state_d = rsm_pkg::ST_APPEND;
            rsm_pkg::OP_MERGE: state_d = rsm_pkg::ST_SCAN;
            rsm_pkg::OP_EMIT:  state_d = (cnt_q == '0) ? rsm_pkg::ST_RESULT
                                                       : rsm_pkg::ST_SORT;
            default:           state_d = rsm_pkg::ST_IDLE;
          endcase
        end
      end
      rsm_pkg::ST_APPEND: state_d = rsm_pkg::ST_RESULT;
      rsm_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = rsm_pkg::ST_EXTEND;
        end else if (pass_end) begin
          state_d = rsm_pkg::ST_APPEND;
        end
      end
      rsm_pkg::ST_EXTEND: state_d = rsm_pkg::ST_RESULT;
      rsm_pkg::ST_SORT: begin
        if (pass_end) begin
          state_d = rsm_pkg::ST_RESULT;
        end
      end
      rsm_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = res_q.last && (res_q.status != rsm_pkg::STATUS_ENTRY || cnt_q == '0)
                    ? rsm_pkg::ST_IDLE : rsm_pkg::ST_SORT;
        end
      end
      default: state_d = rsm_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    off_d        = off_q;
    size_d       = size_q;
    chg_d        = chg_q;
    cnt_d        = cnt_q;
    scan_d       = scan_q;
    rd_pend_d    = 1'b0;
    rd_idx_d     = rd_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_dist_d   = hit_dist_q;
    best_vld_d   = best_vld_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    prev_vld_d   = prev_vld_q;
    prev_start_d = prev_start_q;
    prev_idx_d   = prev_idx_q;
    emit_cnt_d   = emit_cnt_q;
    res_d        = res_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = cnt_q[IdxW-1:0];
    mem_wdata    = '{start: off_q, length: {{(LenW - SizeW){1'b0}}, size_q}, flag: chg_q};

    unique case (state_q)
      rsm_pkg::ST_IDLE: begin
        // capture the beat and arm the scan
        if (in_valid_i) begin
          off_d      = range_offset_i;
          size_d     = range_size_i;
          chg_d      = range_changed_i;
          scan_d     = '0;
          best_vld_d = 1'b0;
          prev_vld_d = 1'b0;
          emit_cnt_d = '0;
          res_d      = '{status: rsm_pkg::STATUS_EMPTY, offset: '0, size: '0,
                         changed: 1'b0, last: 1'b1};
        end
      end
      rsm_pkg::ST_APPEND: begin
        // append at the fill count, or drop when full
        res_d = '{status: rsm_pkg::STATUS_DROPPED, offset: off_q,
                  size: {{(LenW - SizeW){1'b0}}, size_q}, changed: chg_q, last: 1'b1};
        if (room) begin
          mem_we       = 1'b1;
          cnt_d        = cnt_q + CntW'(1);
          res_d.status = rsm_pkg::STATUS_APPENDED;
        end
      end
      rsm_pkg::ST_SCAN: begin
        // walk the table in insertion order, stop at the first hit
        if (hit) begin
          hit_d      = mem_rdata;
          hit_idx_d  = rd_idx_q;
          hit_dist_d = off_delta[OffW-1:0];
        end else if (issue_room) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_idx_d  = scan_q[IdxW-1:0];
          scan_d    = scan_q + CntW'(1);
        end
      end
      rsm_pkg::ST_EXTEND: begin
        // write back the end, raised if the new range reaches past it; entry keeps its flag
        mem_we    = 1'b1;
        mem_waddr = hit_idx_q;
        mem_wdata = '{start: hit_q.start, length: ext_len, flag: hit_q.flag};
        res_d     = '{status: rsm_pkg::STATUS_EXTENDED, offset: hit_q.start,
                      size: ext_len, changed: hit_q.flag, last: 1'b1};
      end
      rsm_pkg::ST_SORT: begin
        // selection pass: smallest key after the previous beat
        if (rd_pend_q && eligible && better) begin
          best_vld_d = 1'b1;
          best_d     = mem_rdata;
          best_idx_d = rd_idx_q;
        end
        if (issue_room) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_idx_d  = scan_q[IdxW-1:0];
          scan_d    = scan_q + CntW'(1);
        end
        if (pass_end) begin
          res_d        = '{status: rsm_pkg::STATUS_ENTRY, offset: best_q.start,
                           size: best_q.length, changed: best_q.flag, last: emit_last};
          prev_vld_d   = 1'b1;
          prev_start_d = best_q.start;
          prev_idx_d   = best_idx_q;
          emit_cnt_d   = emit_cnt_q + CntW'(1);
          scan_d       = '0;
          best_vld_d   = 1'b0;
          if (emit_last) begin
            cnt_d = '0;
          end
        end
      end
      rsm_pkg::ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (state_q == rsm_pkg::ST_RESULT && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsm_pkg::ST_IDLE;
      cnt_q       <= '0;
      scan_q      <= '0;
      rd_pend_q   <= 1'b0;
      best_vld_q  <= 1'b0;
      prev_vld_q  <= 1'b0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      scan_q      <= scan_d;
      rd_pend_q   <= rd_pend_d;
      best_vld_q  <= best_vld_d;
      prev_vld_q  <= prev_vld_d;
      emit_cnt_q  <= emit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    off_q        <= off_d;
    size_q       <= size_d;
    chg_q        <= chg_d;
    rd_idx_q     <= rd_idx_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    hit_dist_q   <= hit_dist_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    prev_start_q <= prev_start_d;
    prev_idx_q   <= prev_idx_d;
    res_q        <= res_d;
    out_q        <= out_d;
  end

  // ports
  assign in_ready_o    = (state_q == rsm_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign out_offset_o  = out_q.offset;
  assign out_size_o    = out_q.size;
  assign out_changed_o = out_q.changed;
  assign last_o        = out_q.last;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableDepth))
    else $error("entry count beyond table depth");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == rsm_pkg::ST_APPEND || state_q == rsm_pkg::ST_EXTEND))
    else $error("table write outside append or extend");

  a_read_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == rsm_pkg::ST_SCAN || state_q == rsm_pkg::ST_SORT))
    else $error("read data pending outside a table walk");

  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsm_pkg::ST_RESULT && res_q.status == rsm_pkg::STATUS_ENTRY && res_q.last)
    |-> cnt_q == '0)
    else $error("table not cleared after final emitted entry");

  a_emit_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsm_pkg::ST_SORT) |-> (emit_cnt_q < cnt_q))
    else $error("sort pass started with every entry already emitted");

endmodule
